// ===== hdl/hbkd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbkd_pkg
// Shared types and constants for the boot-protocol keyboard report decoder.
// ----------------------------------------------------------------------------
package hbkd_pkg;

  localparam int NUM_SLOTS = 6;

  // func codes
  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // shift keys: left shift (bit 1), right shift (bit 5)
  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] LETTER_LO  = 8'h04;
  localparam logic [7:0] LETTER_HI  = 8'h1D;

  typedef logic [7:0] keycode_t;

  typedef struct packed {
    logic                           func;
    logic                           report_complete;
    logic [7:0]                     report_modifiers;
    logic [NUM_SLOTS-1:0][7:0]      key_slots;
    keycode_t                       query_key;
    logic [7:0]                     query_modifiers;
  } item_t;

endpackage

// ===== hdl/hbkd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbkd_in_stage
// Input register: holds one word until it moves to the result register.
// ----------------------------------------------------------------------------
module hbkd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hbkd_pkg::item_t in_item,
  input  logic           advance,
  output logic           stall,
  output logic           s1_valid,
  output hbkd_pkg::item_t s1_item
);
  import hbkd_pkg::*;

  logic accept;

  // stage frees up in the same cycle it hands its word on
  assign stall  = rst || (s1_valid && !advance);
  assign accept = in_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

endmodule

// ===== hdl/hbkd_key_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbkd_key_state
// Held-key state: slots of the last complete report, last key and modifiers.
// The pressed bitmap is exactly the set of nonzero slots of that report, so
// a held check compares the query key against the six stored slots.
// ----------------------------------------------------------------------------
module hbkd_key_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  hbkd_pkg::item_t   item,
  output logic              key_held,
  output hbkd_pkg::keycode_t last_key_next,
  output logic [7:0]        modifiers_next
);
  import hbkd_pkg::*;

  logic [NUM_SLOTS-1:0][7:0] slots;
  keycode_t                  last_key_reg;
  logic [7:0]                modifier_reg;
  keycode_t                  report_last;
  logic [NUM_SLOTS-1:0]      hit;

  always_comb begin
    report_last = last_key_reg;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (item.key_slots[i] != 8'd0) begin
        report_last = item.key_slots[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i] = (slots[i] == item.query_key);
    end
  end

  // keycode 0 marks an empty slot, never held
  assign key_held       = (item.query_key != 8'd0) && (|hit);
  assign last_key_next  = update ? report_last : last_key_reg;
  assign modifiers_next = update ? item.report_modifiers : modifier_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots        <= '0;
      last_key_reg <= 8'd0;
      modifier_reg <= 8'd0;
    end else if (update) begin
      slots        <= item.key_slots;
      last_key_reg <= report_last;
      modifier_reg <= item.report_modifiers;
    end
  end

endmodule

// ===== hdl/hbkd_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbkd_ascii
// Keycode to US-layout ASCII, with shift and caps lock.
// ----------------------------------------------------------------------------
module hbkd_ascii (
  input  hbkd_pkg::keycode_t key,
  input  logic [7:0]         mods,
  input  logic               caps_lock,
  output logic [6:0]         ascii_char
);
  import hbkd_pkg::*;

  function automatic logic [6:0] plain_char(input logic [6:0] k);
    logic [6:0] c;
    c = 7'h00;
    if (k >= 7'h04 && k <= 7'h1D) begin
      c = 7'h61 + (k - 7'h04);
    end else begin
      case (k)
        7'h1E: c = 7'h31;
        7'h1F: c = 7'h32;
        7'h20: c = 7'h33;
        7'h21: c = 7'h34;
        7'h22: c = 7'h35;
        7'h23: c = 7'h36;
        7'h24: c = 7'h37;
        7'h25: c = 7'h38;
        7'h26: c = 7'h39;
        7'h27: c = 7'h30;
        7'h28: c = 7'h0A;
        7'h29: c = 7'h1B;
        7'h2A: c = 7'h08;
        7'h2B: c = 7'h09;
        7'h2C: c = 7'h20;
        7'h2D: c = 7'h2D;
        7'h2E: c = 7'h3D;
        7'h2F: c = 7'h5B;
        7'h30: c = 7'h5D;
        7'h31: c = 7'h5C;
        7'h32: c = 7'h23;
        7'h33: c = 7'h3B;
        7'h34: c = 7'h27;
        7'h35: c = 7'h60;
        7'h36: c = 7'h2C;
        7'h37: c = 7'h2E;
        7'h38: c = 7'h2F;
        default: c = 7'h00;
      endcase
    end
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] k);
    logic [6:0] c;
    c = 7'h00;
    if (k >= 7'h04 && k <= 7'h1D) begin
      c = 7'h41 + (k - 7'h04);
    end else begin
      case (k)
        7'h1E: c = 7'h21;
        7'h1F: c = 7'h40;
        7'h20: c = 7'h23;
        7'h21: c = 7'h24;
        7'h22: c = 7'h25;
        7'h23: c = 7'h5E;
        7'h24: c = 7'h26;
        7'h25: c = 7'h2A;
        7'h26: c = 7'h28;
        7'h27: c = 7'h29;
        7'h28: c = 7'h0A;
        7'h29: c = 7'h1B;
        7'h2A: c = 7'h08;
        7'h2B: c = 7'h09;
        7'h2C: c = 7'h20;
        7'h2D: c = 7'h5F;
        7'h2E: c = 7'h2B;
        7'h2F: c = 7'h7B;
        7'h30: c = 7'h7D;
        7'h31: c = 7'h7C;
        7'h32: c = 7'h7E;
        7'h33: c = 7'h3A;
        7'h34: c = 7'h22;
        7'h35: c = 7'h7E;
        7'h36: c = 7'h3C;
        7'h37: c = 7'h3E;
        7'h38: c = 7'h3F;
        default: c = 7'h00;
      endcase
    end
    return c;
  endfunction

  logic shift;
  logic is_letter;

  assign is_letter = (key >= LETTER_LO) && (key <= LETTER_HI);
  // caps lock flips shift for letters only
  assign shift     = ((mods & SHIFT_MASK) != 8'd0) ^ (is_letter & caps_lock);

  always_comb begin
    if (key[7]) begin
      ascii_char = 7'h00;
    end else if (shift) begin
      ascii_char = shifted_char(key[6:0]);
    end else begin
      ascii_char = plain_char(key[6:0]);
    end
  end

endmodule

// ===== hdl/hid_boot_keyboard_decoder_core.sv =====
`timescale 1ns / 1ps
// Each word passes the input register, then the result register.
// Throughput: one word per cycle unless the result is stalled; the result
// register accepts a new word in the cycle its current word is taken.
// Reset (rst, synchronous): clears held keys, last key, modifiers, caps lock
// and both pipeline valids; input is stalled while rst is high.
// ----------------------------------------------------------------------------
// hid_boot_keyboard_decoder_core
// Boot-protocol keyboard report decoder: complete report words update the
// held-key state; query words return held status and a key's ASCII character.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_decoder_core (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // item channel
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       func,
  input  logic       report_complete,
  input  logic [7:0] report_modifiers,
  input  logic [7:0] key_slot0,
  input  logic [7:0] key_slot1,
  input  logic [7:0] key_slot2,
  input  logic [7:0] key_slot3,
  input  logic [7:0] key_slot4,
  input  logic [7:0] key_slot5,
  input  logic [7:0] query_key,
  input  logic [7:0] query_modifiers,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic       key_held,
  output logic [6:0] ascii_char,
  output logic [7:0] last_key,
  output logic [7:0] held_modifiers
);
  import hbkd_pkg::*;

  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       advance;
  logic       caps_lock;
  logic       update;
  logic       held_raw;
  keycode_t   last_key_next;
  logic [7:0] modifiers_next;
  logic [6:0] ascii_raw;
  logic       is_query;

  always_comb begin
    in_item.func             = func;
    in_item.report_complete  = report_complete;
    in_item.report_modifiers = report_modifiers;
    in_item.key_slots[0]     = key_slot0;
    in_item.key_slots[1]     = key_slot1;
    in_item.key_slots[2]     = key_slot2;
    in_item.key_slots[3]     = key_slot3;
    in_item.key_slots[4]     = key_slot4;
    in_item.key_slots[5]     = key_slot5;
    in_item.query_key        = query_key;
    in_item.query_modifiers  = query_modifiers;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      caps_lock <= 1'b0;
    end else if (cfg_wr_en) begin
      caps_lock <= cfg_wr_data;
    end
  end

  assign advance  = s1_valid && (!result_valid || !result_stall);
  assign is_query = (s1_item.func == FUNC_QUERY);
  assign update   = advance && (s1_item.func == FUNC_REPORT) && s1_item.report_complete;

  hbkd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_item  (in_item),
    .advance  (advance),
    .stall    (item_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  hbkd_key_state u_key_state (
    .clk            (clk),
    .rst            (rst),
    .update         (update),
    .item           (s1_item),
    .key_held       (held_raw),
    .last_key_next  (last_key_next),
    .modifiers_next (modifiers_next)
  );

  hbkd_ascii u_ascii (
    .key        (s1_item.query_key),
    .mods       (s1_item.query_modifiers),
    .caps_lock  (caps_lock),
    .ascii_char (ascii_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // report words return zero held/char fields
  always_ff @(posedge clk) begin
    if (advance) begin
      key_held       <= is_query & held_raw;
      ascii_char     <= is_query ? ascii_raw : 7'h00;
      last_key       <= last_key_next;
      held_modifiers <= modifiers_next;
    end
  end

endmodule

// ===== hdl/hbkd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbkd_checker
// Port-level checks for the keyboard decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module hbkd_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic       key_held,
  input logic [6:0] ascii_char,
  input logic [7:0] last_key,
  input logic [7:0] held_modifiers
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable({key_held, ascii_char, last_key, held_modifiers}))
    else $error("result word changed while stalled");

  // input only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with room in the pipeline");

  // a fresh result comes from an accepted word, by way of the input register
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
    else $error("result appeared without an accepted word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind hid_boot_keyboard_decoder_core hbkd_checker u_hbkd_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item_valid),
  .item_stall     (item_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .key_held       (key_held),
  .ascii_char     (ascii_char),
  .last_key       (last_key),
  .held_modifiers (held_modifiers)
);
